// File: rtl/cstr_pkg.sv
// ----------------------------------------------------------------------------
// cstr_pkg
// shared types and constants of the context switch trace recorder
// ----------------------------------------------------------------------------
`default_nettype none

package cstr_pkg;

   localparam int THREAD_SLOTS = 8;
   localparam int SLOT_W       = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
   localparam int ID_W         = $clog2(THREAD_SLOTS + 1);

   localparam int TIME_W       = 32;
   localparam int HANDLE_W     = 32;
   localparam int STATE_W      = 4;
   localparam int ENTITY_W     = 16;
   localparam int KIND_SHIFT   = 14;
   localparam int ENT_ID_W     = 14;
   localparam int REASON_W     = 2;
   localparam int START_W      = 24;
   localparam int DUR_W        = 16;
   localparam int SEQ_W        = 32;

   localparam int REQ_DATA_W   = 72;
   localparam int RSP_DATA_W   = 96;

   // outgoing thread states
   localparam logic [STATE_W-1:0] TSTATE_READY    = 4'd0;
   localparam logic [STATE_W-1:0] TSTATE_DONE     = 4'd1;
   localparam logic [STATE_W-1:0] TSTATE_DONE_ALT = 4'd2;
   localparam logic [STATE_W-1:0] TSTATE_SLEEP    = 4'd4;

   typedef enum logic [1:0] {
      FUNC_ISR_ENTER    = 2'd0,
      FUNC_ISR_EXIT     = 2'd1,
      FUNC_THREAD_EXIT  = 2'd2,
      FUNC_THREAD_ENTER = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ENTITY_ISR    = 2'd0,
      ENTITY_THREAD = 2'd1
   } kind_type;

   typedef enum logic [1:0] {
      LEAVE_PREEMPT = 2'd0,
      LEAVE_BLOCK   = 2'd1,
      LEAVE_YIELD   = 2'd2,
      LEAVE_EXIT    = 2'd3
   } reason_type;

   typedef struct packed {
      logic                start;
      logic [HANDLE_W-1:0] handle;
   } lookup_req_type;

   typedef struct packed {
      logic            done;
      logic [ID_W-1:0] id;
   } lookup_rsp_type;

endpackage

`default_nettype wire

// File: rtl/cstr_id_lookup.sv
// ----------------------------------------------------------------------------
// cstr_id_lookup
// handle to id table, one shared compare per cycle over the known slots,
// assigns the next id on first sight while a slot is free
// ----------------------------------------------------------------------------
`default_nettype none

module cstr_id_lookup
   import cstr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire lookup_req_type lookup_req,
   output lookup_rsp_type      lookup_rsp
);

   typedef enum logic [2:0] {
      LK_IDLE = 3'b001,
      LK_SCAN = 3'b010,
      LK_DONE = 3'b100
   } lk_state_type;

   lk_state_type        state_ff, state_in;
   logic [ID_W-1:0]     idx_ff, idx_in;
   logic [ID_W-1:0]     known_ff, known_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic                wr_en;
   logic                hit;

   logic [HANDLE_W-1:0] table_ff [THREAD_SLOTS];

   assign hit = (table_ff[idx_ff[SLOT_W-1:0]] == handle_ff);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      known_in  = known_ff;
      id_in     = id_ff;
      handle_in = handle_ff;
      wr_en     = 1'b0;
      unique case (state_ff)
         LK_IDLE: begin
            if (lookup_req.start) begin
               handle_in = lookup_req.handle;
               idx_in    = '0;
               id_in     = '0;
               if (lookup_req.handle == '0) begin
                  state_in = LK_DONE;
               end else begin
                  state_in = LK_SCAN;
               end
            end
         end
         LK_SCAN: begin
            if (idx_ff < known_ff) begin
               if (hit) begin
                  id_in    = idx_ff + 1'b1;
                  state_in = LK_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               if (known_ff < ID_W'(THREAD_SLOTS)) begin
                  wr_en    = 1'b1;
                  id_in    = known_ff + 1'b1;
                  known_in = known_ff + 1'b1;
               end else begin
                  id_in = '0;
               end
               state_in = LK_DONE;
            end
         end
         LK_DONE: begin
            state_in = LK_IDLE;
         end
         default: begin
            state_in = LK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LK_IDLE;
         known_ff <= '0;
      end else begin
         state_ff <= state_in;
         known_ff <= known_in;
      end
      idx_ff    <= idx_in;
      id_ff     <= id_in;
      handle_ff <= handle_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[known_ff[SLOT_W-1:0]] <= handle_ff;
      end
   end

   assign lookup_rsp.done = (state_ff == LK_DONE);
   assign lookup_rsp.id   = id_ff;

endmodule

`default_nettype wire

// File: rtl/context_switch_trace_recorder.sv
// ----------------------------------------------------------------------------
// context_switch_trace_recorder
// turns time stamped scheduler events into isr and thread interval records
// ----------------------------------------------------------------------------
// usage
//   req_ carries one scheduler event: event code in req_tuser, time, handle
//   and outgoing state in req_tdata. rsp_ carries one trace record for each
//   finished isr or thread interval.
//   isr enter and thread exit requests only update registers; an isr exit
//   request goes to the emit state, which loads its record into the output
//   register once that register is free. a thread enter request runs the
//   outgoing handle through the id table, one slot compared per cycle by a
//   single comparator: the scan compares the known slots up to a match,
//   adds or refuses a new handle if none matches, and is skipped for handle
//   zero; a record goes through the emit state only when an id is found or given.
//   a new request is taken while a finished record still waits in the output
//   register; if a second record is ready before the first is taken, the
//   block holds off further requests until the output register frees up.
//   reset is synchronous: counters, running thread, isr and run start times
//   and the id count return to zero at once; the table needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module context_switch_trace_recorder
   import cstr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // timestamp_us[31:0], thread_handle[63:32], thread_state[67:64], zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // func[1:0]
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // entity_word[15:0], reason[17:16], start_low[41:18], run_duration[57:42],
   // sequence_res[89:58], zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [TIME_W-1:0]   isr_since_ff, isr_since_in;
   logic [HANDLE_W-1:0] running_handle_ff, running_handle_in;
   logic [TIME_W-1:0]   running_since_ff, running_since_in;
   reason_type          leave_reason_ff, leave_reason_in;
   logic [SEQ_W-1:0]    records_ff, records_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [HANDLE_W-1:0] next_handle_ff, next_handle_in;
   logic                lookup_start_ff, lookup_start_in;

   logic [ENTITY_W-1:0] pend_entity_ff, pend_entity_in;
   reason_type          pend_reason_ff, pend_reason_in;
   logic [TIME_W-1:0]   pend_start_ff, pend_start_in;
   logic [TIME_W-1:0]   pend_end_ff, pend_end_in;

   logic                out_valid_ff, out_valid_in;
   logic [ENTITY_W-1:0] out_entity_ff, out_entity_in;
   reason_type          out_reason_ff, out_reason_in;
   logic [START_W-1:0]  out_start_ff, out_start_in;
   logic [DUR_W-1:0]    out_dur_ff, out_dur_in;
   logic [SEQ_W-1:0]    out_seq_ff, out_seq_in;

   lookup_req_type      lookup_req;
   lookup_rsp_type      lookup_rsp;

   logic                req_fire;
   logic                out_free;
   func_type            func;
   logic [TIME_W-1:0]   req_time;
   logic [HANDLE_W-1:0] req_handle;
   logic [STATE_W-1:0]  req_state;
   logic [TIME_W-1:0]   span;

   function automatic reason_type map_reason(input logic [STATE_W-1:0] st);
      reason_type r;
      case (st) inside
         TSTATE_READY:                 r = LEAVE_PREEMPT;
         TSTATE_SLEEP:                 r = LEAVE_YIELD;
         TSTATE_DONE, TSTATE_DONE_ALT: r = LEAVE_EXIT;
         default:                      r = LEAVE_BLOCK;
      endcase
      return r;
   endfunction

   assign func       = func_type'(req_tuser);
   assign req_time   = req_tdata[31:0];
   assign req_handle = req_tdata[63:32];
   assign req_state  = req_tdata[67:64];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign span       = pend_end_ff - pend_start_ff;

   assign lookup_req.start  = lookup_start_ff;
   assign lookup_req.handle = running_handle_ff;

   cstr_id_lookup u_id_lookup (
      .clock      (clock),
      .reset      (reset),
      .lookup_req (lookup_req),
      .lookup_rsp (lookup_rsp)
   );

   always_comb begin
      state_in          = state_ff;
      isr_since_in      = isr_since_ff;
      running_handle_in = running_handle_ff;
      running_since_in  = running_since_ff;
      leave_reason_in   = leave_reason_ff;
      records_in        = records_ff;
      now_in            = now_ff;
      next_handle_in    = next_handle_ff;
      lookup_start_in   = 1'b0;
      pend_entity_in    = pend_entity_ff;
      pend_reason_in    = pend_reason_ff;
      pend_start_in     = pend_start_ff;
      pend_end_in       = pend_end_ff;
      out_valid_in      = out_valid_ff && !rsp_tready;
      out_entity_in     = out_entity_ff;
      out_reason_in     = out_reason_ff;
      out_start_in      = out_start_ff;
      out_dur_in        = out_dur_ff;
      out_seq_in        = out_seq_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (func)
                  FUNC_ISR_ENTER: begin
                     isr_since_in = req_time;
                  end
                  FUNC_ISR_EXIT: begin
                     pend_entity_in = {ENTITY_ISR, ENT_ID_W'(0)};
                     pend_reason_in = LEAVE_PREEMPT;
                     pend_start_in  = isr_since_ff;
                     pend_end_in    = req_time;
                     state_in       = ST_EMIT;
                  end
                  FUNC_THREAD_EXIT: begin
                     leave_reason_in = (req_handle != '0) ? map_reason(req_state)
                                                          : LEAVE_BLOCK;
                  end
                  FUNC_THREAD_ENTER: begin
                     now_in          = req_time;
                     next_handle_in  = req_handle;
                     lookup_start_in = 1'b1;
                     state_in        = ST_LOOKUP;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            if (lookup_rsp.done) begin
               pend_entity_in    = {ENTITY_THREAD, ENT_ID_W'(lookup_rsp.id)};
               pend_reason_in    = leave_reason_ff;
               pend_start_in     = running_since_ff;
               pend_end_in       = now_ff;
               running_handle_in = next_handle_ff;
               running_since_in  = now_ff;
               state_in          = (lookup_rsp.id != '0) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_entity_in = pend_entity_ff;
               out_reason_in = pend_reason_ff;
               out_start_in  = pend_start_ff[START_W-1:0];
               out_dur_in    = (span[TIME_W-1:DUR_W] != '0) ? {DUR_W{1'b1}}
                                                            : span[DUR_W-1:0];
               out_seq_in    = records_ff;
               records_in    = records_ff + 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         isr_since_ff      <= '0;
         running_handle_ff <= '0;
         running_since_ff  <= '0;
         leave_reason_ff   <= LEAVE_PREEMPT;
         records_ff        <= '0;
         lookup_start_ff   <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         isr_since_ff      <= isr_since_in;
         running_handle_ff <= running_handle_in;
         running_since_ff  <= running_since_in;
         leave_reason_ff   <= leave_reason_in;
         records_ff        <= records_in;
         lookup_start_ff   <= lookup_start_in;
         out_valid_ff      <= out_valid_in;
      end
      now_ff         <= now_in;
      next_handle_ff <= next_handle_in;
      pend_entity_ff <= pend_entity_in;
      pend_reason_ff <= pend_reason_in;
      pend_start_ff  <= pend_start_in;
      pend_end_ff    <= pend_end_in;
      out_entity_ff  <= out_entity_in;
      out_reason_ff  <= out_reason_in;
      out_start_ff   <= out_start_in;
      out_dur_ff     <= out_dur_in;
      out_seq_ff     <= out_seq_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_seq_ff, out_dur_ff, out_start_ff, out_reason_ff,
                        out_entity_ff};

endmodule

`default_nettype wire

// File: rtl/cstr_checker.sv
// ----------------------------------------------------------------------------
// cstr_checker
// port level checks of the context switch trace recorder, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

module cstr_checker
   import cstr_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [1:0]            req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // stalled record holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled record changed");

   // sequence numbers step by one between back to back records
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=>
         !rsp_tvalid || (rsp_tdata[89:58] == $past(rsp_tdata[89:58]) + 32'd1))
      else $error("sequence number skipped");

   // thread enter starts a table lookup that blocks requests
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == FUNC_THREAD_ENTER) |=> !req_tready)
      else $error("request taken during lookup");

   // isr records carry no reason and id
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[15:14] == ENTITY_ISR) |->
         (rsp_tdata[17:16] == LEAVE_PREEMPT) && (rsp_tdata[13:0] == 14'd0))
      else $error("isr record with reason or id");

   // no record right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("record valid after reset");

endmodule

bind context_switch_trace_recorder cstr_checker u_cstr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: tb/context_switch_trace_recorder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// context_switch_trace_recorder_tb
// self-checking bench: scheduler events go in, the predicted isr and thread
// interval records are compared field by field with the records that come out,
// under random idling on both sides and with back pressure on the output
// ----------------------------------------------------------------------------

module context_switch_trace_recorder_tb
   import cstr_pkg::*;
();

   typedef struct packed {
      logic [ENTITY_W-1:0] entity;
      reason_type          reason;
      logic [START_W-1:0]  start_low;
      logic [DUR_W-1:0]    span;
      logic [SEQ_W-1:0]    seq;
   } trace_rec_type;

   // interval predictor and store of the records still to come
   class trace_scoreboard_type;
      logic [HANDLE_W-1:0] handle_slots[THREAD_SLOTS];
      int unsigned         ids_given = 0;
      logic [HANDLE_W-1:0] running_handle = '0;
      logic [TIME_W-1:0]   running_since = '0;
      logic [TIME_W-1:0]   isr_since = '0;
      logic [SEQ_W-1:0]    records_made = '0;
      reason_type          leave_why = LEAVE_PREEMPT;
      trace_rec_type       due_records[$];
      int                  errors = 0;

      function void note_event(func_type f, logic [TIME_W-1:0] ts,
                               logic [HANDLE_W-1:0] h, logic [STATE_W-1:0] st);
         trace_rec_type     rec;
         logic [TIME_W-1:0] from;
         logic [TIME_W-1:0] elapsed;
         kind_type          kind;
         reason_type        why;
         int unsigned       id;
         bit                closes;
         closes = 0;
         id = 0;
         from = '0;
         kind = ENTITY_ISR;
         why = LEAVE_PREEMPT;
         case (f)
            FUNC_ISR_ENTER: isr_since = ts;
            FUNC_ISR_EXIT: begin
               closes = 1;
               from = isr_since;
            end
            FUNC_THREAD_EXIT: begin
               if (h == '0) leave_why = LEAVE_BLOCK;
               else begin
                  case (st) inside
                     TSTATE_READY:                 leave_why = LEAVE_PREEMPT;
                     TSTATE_SLEEP:                 leave_why = LEAVE_YIELD;
                     TSTATE_DONE, TSTATE_DONE_ALT: leave_why = LEAVE_EXIT;
                     default:                      leave_why = LEAVE_BLOCK;
                  endcase
               end
            end
            default: begin
               if (running_handle != '0) begin
                  for (int i = 0; i < int'(ids_given); i++)
                     if (id == 0 && handle_slots[i] == running_handle) id = i + 1;
                  if (id == 0 && ids_given < THREAD_SLOTS) begin
                     handle_slots[ids_given] = running_handle;
                     ids_given++;
                     id = ids_given;
                  end
               end
               closes = (id != 0);
               from = running_since;
               kind = ENTITY_THREAD;
               why = leave_why;
               running_handle = h;
               running_since = ts;
            end
         endcase
         if (closes) begin
            elapsed = ts - from;
            rec.entity = {kind, ENT_ID_W'(id)};
            rec.reason = why;
            rec.start_low = from[START_W-1:0];
            rec.span = (elapsed > 32'd65535) ? 16'hFFFF : elapsed[DUR_W-1:0];
            rec.seq = records_made;
            records_made++;
            due_records.push_back(rec);
         end
      endfunction

      function void check_record(logic [RSP_DATA_W-1:0] d);
         trace_rec_type want;
         logic [31:0]   got_f[5];
         logic [31:0]   want_f[5];
         string         names[5];
         if (due_records.size() == 0) begin
            $display("%0t: unexpected record, expected none, actual %h", $time, d);
            errors++;
            return;
         end
         want = due_records.pop_front();
         names = '{"entity_word", "reason", "start_low", "run_duration", "sequence_res"};
         got_f = '{32'(d[15:0]), 32'(d[17:16]), 32'(d[41:18]), 32'(d[57:42]),
                   d[89:58]};
         want_f = '{32'(want.entity), 32'(want.reason), 32'(want.start_low),
                    32'(want.span), want.seq};
         for (int i = 0; i < 5; i++) begin
            if (got_f[i] !== want_f[i]) begin
               $display("%0t: record %0d %s expected %h actual %h",
                        $time, want.seq, names[i], want_f[i], got_f[i]);
               errors++;
            end
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   trace_scoreboard_type  sb;
   int                    send_idle = 0;
   int                    recv_idle = 0;
   int                    hold_left = 0;
   bit                    long_hold = 0;
   int unsigned           items_sent = 0;
   logic [TIME_W-1:0]     now_us = '0;
   logic [HANDLE_W-1:0]   running_now = '0;
   logic [HANDLE_W-1:0]   handle_pool[9] = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                                             32'h1234_5678, 32'h0000_1000, 32'hDEAD_BEEF,
                                             32'h5555_5555, 32'hAAAA_AAAA, 32'h0BAD_F00D};
   logic [STATE_W-1:0]    usual_states[4] = '{TSTATE_READY, TSTATE_DONE, TSTATE_DONE_ALT,
                                              TSTATE_SLEEP};

   context_switch_trace_recorder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (long_hold) begin
         hold_left = 300;
         long_hold = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_record(rsp_tdata);
   end

   function automatic logic [TIME_W-1:0] next_stamp();
      if ($urandom_range(15) == 0) now_us += $urandom;
      else now_us += $urandom_range(3000);
      return now_us;
   endfunction

   task automatic send_event(input func_type f, input logic [TIME_W-1:0] ts,
                             input logic [HANDLE_W-1:0] h, input logic [STATE_W-1:0] st);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= {4'b0, st, h, ts};
      do @(posedge clock); while (!req_tready);
      sb.note_event(f, ts, h, st);
      items_sent++;
      if (f == FUNC_THREAD_ENTER) running_now = h;
   endtask

   task automatic drain_records();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.due_records.size() != 0) @(posedge clock);
   endtask

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [STATE_W-1:0]  dir_states[9];
      logic [STATE_W-1:0]  st;
      logic [HANDLE_W-1:0] h;
      int unsigned         target;
      int unsigned         roll;
      sb = new();
      dir_states = '{4'd0, 4'd4, 4'd1, 4'd2, 4'd3, 4'd15, 4'd8, 4'd0, 4'd5};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // isr exit with no isr enter, saturation, wrap of the time
      send_event(FUNC_ISR_EXIT, 32'h0, 32'h0, 4'h0);
      send_event(FUNC_ISR_EXIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
      send_event(FUNC_ISR_ENTER, 32'hFFFF_FFF0, 32'h0, 4'h0);
      send_event(FUNC_ISR_EXIT, 32'h10, 32'h0, 4'h0);
      // thread exit with no handle
      send_event(FUNC_THREAD_EXIT, 32'h20, 32'h0, 4'h0);
      now_us = 32'h100;
      send_event(FUNC_THREAD_ENTER, now_us, handle_pool[0], 4'h0);
      // every state mapping, fill the id table and run past it, then go idle
      for (int i = 1; i < 10; i++) begin
         now_us += (i == 5) ? 32'h0002_0000 : 32'(50 * i);
         send_event(FUNC_THREAD_EXIT, now_us, running_now, dir_states[i-1]);
         now_us += 1;
         send_event(FUNC_THREAD_ENTER, now_us, (i < 9) ? handle_pool[i] : 32'h0, 4'h0);
      end

      for (int phase = 0; phase < 3; phase++) begin
         drain_records();
         send_idle = (phase == 0) ? 12 : (phase == 1) ? 45 : 0;
         recv_idle = (phase == 0) ? 45 : (phase == 1) ? 12 : 0;
         if (phase == 2) long_hold = 1;
         target = items_sent + 434;
         while (items_sent < target) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
               // context switch: outgoing thread leaves, next one comes in
               st = ($urandom_range(9) < 6) ? usual_states[$urandom_range(3)]
                                            : 4'($urandom_range(15));
               send_event(FUNC_THREAD_EXIT, next_stamp(), running_now, st);
               roll = $urandom_range(99);
               h = (roll < 75) ? handle_pool[$urandom_range(8)]
                 : (roll < 85) ? 32'h0 : 32'($urandom);
               send_event(FUNC_THREAD_ENTER, next_stamp(), h, 4'($urandom_range(15)));
            end else if (roll < 75) begin
               send_event(FUNC_ISR_ENTER, next_stamp(), running_now, 4'($urandom_range(15)));
               send_event(FUNC_ISR_EXIT, next_stamp(), running_now, 4'($urandom_range(15)));
            end else begin
               // stray event with random content
               h = ($urandom_range(1) == 0) ? handle_pool[$urandom_range(8)]
                                            : 32'($urandom);
               send_event(func_type'(2'($urandom_range(3))), 32'($urandom), h,
                          4'($urandom_range(15)));
            end
         end
      end

      drain_records();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.due_records.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
